// File: hdl/stn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stn_pkg: shared types and constants of the source text normalizer
// Byte codes, parser states, rule actions and the request record that the
// front part hands to the back part through the request queue.
// ----------------------------------------------------------------------------
package stn_pkg;

    // Width of a source position.
    localparam int IDX_W = 32;

    // Request queue geometry.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Configuration register indexes (byte address / 4).
    localparam logic [1:0] REG_WORD_MODE  = 2'd0;
    localparam logic [1:0] REG_EOF_MARKER = 2'd1;
    localparam logic [1:0] REG_EXTRA_BLANK = 2'd2;

    // Configuration reset values.
    localparam logic [7:0] EOF_MARKER_RST  = 8'hFF;
    localparam logic [7:0] EXTRA_BLANK_RST = 8'h0C;

    // Byte codes.
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_VT      = 8'h0B;
    localparam logic [7:0] CH_FF      = 8'h0C;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_SQUOTE  = 8'h27;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_LC_I    = 8'h69;
    localparam logic [7:0] CH_LC_M    = 8'h6D;
    localparam logic [7:0] CH_LC_P    = 8'h70;
    localparam logic [7:0] CH_LC_O    = 8'h6F;
    localparam logic [7:0] CH_LC_R    = 8'h72;
    localparam logic [7:0] CH_LC_T    = 8'h74;
    localparam logic [7:0] CH_LC_U    = 8'h75;
    localparam logic [7:0] CH_LC_S    = 8'h73;
    localparam logic [7:0] CH_LC_N    = 8'h6E;
    localparam logic [7:0] CH_LC_G    = 8'h67;

    // Source languages.
    typedef enum logic [2:0] {
        LANG_OTHER  = 3'd0,
        LANG_CFAM   = 3'd1,
        LANG_ERL    = 3'd2,
        LANG_SCRIPT = 3'd3,
        LANG_PY     = 3'd4
    } t_lang;

    // Parser states.
    typedef enum logic [4:0] {
        S_NORMAL, S_CSTART, S_CCOM, S_CCEND, S_REGEXP, S_DQ, S_DQ1, S_DQ2,
        S_DQ3, S_DQ4, S_DQ5, S_SQ1, S_SQ2, S_SQ3, S_SQ4, S_SQ5, S_SQ, S_ESCD,
        S_ESCS, S_SKIP, S_SPACE
    } t_state;

    // Rule actions.
    typedef enum logic [2:0] {
        A_NONE, A_SLASH_CHAR, A_CHAR, A_MARK, A_SPACE
    } t_act;

    // Result of a rule lookup.
    typedef struct packed {
        logic   hit;
        t_state to;
        t_act   act;
    } t_rule;

    // Configuration seen by the front part.
    typedef struct packed {
        logic       word_mode;
        logic [7:0] eof_marker;
        logic [7:0] extra_blank;
    } t_cfg;

    // One request: one or two output bytes caused by one input byte.
    typedef struct packed {
        logic [7:0]       ch0;
        logic [7:0]       ch1;
        logic [IDX_W-1:0] idx;
        logic             dec0;
        logic             bm0;
        logic             bm1;
        logic             two;
    } t_job;

endpackage

// File: hdl/stn_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stn_front: parser front part
// Holds the parser state and the pending bookmark flag, looks up the
// transition for each accepted byte combinationally and pushes a request for the
// bytes to emit into the request queue.
// ----------------------------------------------------------------------------
module stn_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  stn_pkg::t_cfg        i_cfg,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [7:0]           i_current_char,
    input  logic [7:0]           i_ahead_1,
    input  logic [7:0]           i_ahead_2,
    input  logic [7:0]           i_ahead_3,
    input  logic [7:0]           i_ahead_4,
    input  logic [7:0]           i_ahead_5,
    input  logic [2:0]           i_language,
    input  logic [stn_pkg::IDX_W-1:0] i_source_index,
    input  logic                 i_q_full,
    output logic                 o_push,
    output stn_pkg::t_job        o_job
);
    import stn_pkg::*;

    t_state r_state, n_state;
    logic   r_bm_pending, n_bm_pending;
    t_lang  lang;
    t_rule  rule;
    t_job   job;
    logic   emit;
    logic   accept;
    logic   kw_import, kw_using, blank_c, word_blank;
    logic [7:0] c;

    // Code rules, language specific entries first, then common entries.
    function automatic t_rule code_rule(t_state st, t_lang lg, logic [7:0] ch);
        t_rule r;
        r = '{hit: 1'b1, to: st, act: A_NONE};
        unique case (st)
            S_NORMAL: begin
                if (lg == LANG_ERL && ch == CH_HASH) begin
                    r.to = S_NORMAL;
                end else if (lg == LANG_ERL && ch == CH_PERCENT) begin
                    r.to = S_SKIP;
                end else if (lg == LANG_PY && ch == CH_DQUOTE) begin
                    r.to = S_DQ1;
                end else if (lg == LANG_PY && ch == CH_SQUOTE) begin
                    r.to = S_SQ1;
                end else if (lg == LANG_SCRIPT && ch == CH_SLASH) begin
                    r.to  = S_REGEXP;
                    r.act = A_CHAR;
                end else begin
                    case (ch) inside
                        CH_SLASH:        r.to = S_CSTART;
                        CH_DQUOTE:       begin r.to = S_DQ; r.act = A_CHAR; end
                        CH_SQUOTE:       begin r.to = S_SQ; r.act = A_CHAR; end
                        CH_LF:           begin r.to = S_NORMAL; r.act = A_MARK; end
                        CH_SPACE, CH_TAB: r.to = S_NORMAL;
                        CH_HASH:         r.to = S_SKIP;
                        default:         r.hit = 1'b0;
                    endcase
                end
            end
            S_CSTART: begin
                case (ch) inside
                    CH_STAR:  r.to = S_CCOM;
                    CH_SLASH: r.to = S_SKIP;
                    default:  begin r.to = S_NORMAL; r.act = A_SLASH_CHAR; end
                endcase
            end
            S_CCOM: begin
                if (ch == CH_STAR) r.to = S_CCEND;
                else               r.hit = 1'b0;
            end
            S_CCEND: begin
                case (ch) inside
                    CH_SLASH: r.to = S_NORMAL;
                    CH_STAR:  r.to = S_CCEND;
                    default:  r.to = S_CCOM;
                endcase
            end
            S_REGEXP: begin
                if (lg == LANG_SCRIPT && ch == CH_SLASH) begin
                    r.to = S_SKIP;
                end else if (lg == LANG_SCRIPT && ch == CH_STAR) begin
                    r.to = S_CCOM;
                end else if (lg == LANG_SCRIPT && ch == CH_LF) begin
                    r.to  = S_NORMAL;
                    r.act = A_CHAR;
                end else begin
                    r.hit = 1'b0;
                end
            end
            S_DQ: begin
                r.act = A_CHAR;
                case (ch) inside
                    CH_BSLASH: r.to = S_ESCD;
                    CH_DQUOTE: r.to = S_NORMAL;
                    CH_LF:     begin r.to = S_NORMAL; r.act = A_MARK; end
                    default:   r.to = S_DQ;
                endcase
            end
            S_SQ: begin
                r.act = A_CHAR;
                case (ch) inside
                    CH_BSLASH: r.to = S_ESCS;
                    CH_SQUOTE: r.to = S_NORMAL;
                    CH_LF:     begin r.to = S_NORMAL; r.act = A_MARK; end
                    default:   r.to = S_SQ;
                endcase
            end
            S_ESCD: begin r.to = S_DQ; r.act = A_CHAR; end
            S_ESCS: begin r.to = S_SQ; r.act = A_CHAR; end
            S_SKIP: begin
                if (ch == CH_LF) begin
                    r.to  = S_NORMAL;
                    r.act = A_MARK;
                end else begin
                    r.hit = 1'b0;
                end
            end
            // Python triple quotes: only Python bytes have rules here.
            S_DQ1: begin
                if (lg != LANG_PY)        r.hit = 1'b0;
                else if (ch == CH_DQUOTE) r.to = S_DQ2;
                else                      begin r.to = S_DQ; r.act = A_CHAR; end
            end
            S_DQ2: begin
                if (lg != LANG_PY)        r.hit = 1'b0;
                else if (ch == CH_DQUOTE) r.to = S_DQ3;
                else                      begin r.to = S_NORMAL; r.act = A_CHAR; end
            end
            S_DQ3: begin
                if (lg != LANG_PY)        r.hit = 1'b0;
                else if (ch == CH_DQUOTE) r.to = S_DQ4;
                else                      r.to = S_DQ3;
            end
            S_DQ4: begin
                if (lg != LANG_PY)        r.hit = 1'b0;
                else if (ch == CH_DQUOTE) r.to = S_DQ5;
                else                      r.to = S_DQ3;
            end
            S_DQ5: begin
                if (lg != LANG_PY)        r.hit = 1'b0;
                else if (ch == CH_DQUOTE) r.to = S_NORMAL;
                else                      r.to = S_DQ3;
            end
            S_SQ1: begin
                if (lg != LANG_PY)        r.hit = 1'b0;
                else if (ch == CH_SQUOTE) r.to = S_SQ2;
                else                      begin r.to = S_SQ; r.act = A_CHAR; end
            end
            S_SQ2: begin
                if (lg != LANG_PY)        r.hit = 1'b0;
                else if (ch == CH_SQUOTE) r.to = S_SQ3;
                else                      begin r.to = S_NORMAL; r.act = A_CHAR; end
            end
            S_SQ3: begin
                if (lg != LANG_PY)        r.hit = 1'b0;
                else if (ch == CH_SQUOTE) r.to = S_SQ4;
                else                      r.to = S_SQ3;
            end
            S_SQ4: begin
                if (lg != LANG_PY)        r.hit = 1'b0;
                else if (ch == CH_SQUOTE) r.to = S_SQ5;
                else                      r.to = S_SQ3;
            end
            S_SQ5: begin
                if (lg != LANG_PY)        r.hit = 1'b0;
                else if (ch == CH_SQUOTE) r.to = S_NORMAL;
                else                      r.to = S_SQ3;
            end
            default: r.hit = 1'b0;
        endcase
        return r;
    endfunction

    // Word rules: blank bytes collapse into one space.
    function automatic t_rule word_rule(t_state st, logic is_blank);
        t_rule r;
        r = '{hit: 1'b1, to: st, act: A_NONE};
        unique case (st)
            S_NORMAL: begin
                if (is_blank) r.to = S_SPACE;
                else          begin r.to = S_NORMAL; r.act = A_CHAR; end
            end
            S_SPACE: begin
                if (is_blank) r.to = S_SPACE;
                else          begin r.to = S_NORMAL; r.act = A_SPACE; end
            end
            default: r.hit = 1'b0;
        endcase
        return r;
    endfunction

    assign c = i_current_char;

    // Language codes beyond the known set count as other.
    always_comb begin
        unique case (i_language)
            LANG_CFAM:   lang = LANG_CFAM;
            LANG_ERL:    lang = LANG_ERL;
            LANG_SCRIPT: lang = LANG_SCRIPT;
            LANG_PY:     lang = LANG_PY;
            default:     lang = LANG_OTHER;
        endcase
    end

    // Byte classes and keyword lookahead.
    assign blank_c = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
                     (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
    assign word_blank = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) ||
                        (c == CH_LF) || (c == i_cfg.extra_blank);
    assign kw_import = (c == CH_LC_I) && (i_ahead_1 == CH_LC_M) &&
                       (i_ahead_2 == CH_LC_P) && (i_ahead_3 == CH_LC_O) &&
                       (i_ahead_4 == CH_LC_R) && (i_ahead_5 == CH_LC_T);
    assign kw_using = (c == CH_LC_U) && (i_ahead_1 == CH_LC_S) &&
                      (i_ahead_2 == CH_LC_I) && (i_ahead_3 == CH_LC_N) &&
                      (i_ahead_4 == CH_LC_G);

    assign rule = i_cfg.word_mode ? word_rule(r_state, word_blank)
                                  : code_rule(r_state, lang, c);

    // Action decode: next state, pending bookmark and the request to queue.
    always_comb begin
        n_state      = r_state;
        n_bm_pending = r_bm_pending;
        emit         = 1'b0;
        job.ch0      = c;
        job.ch1      = c;
        job.idx      = i_source_index;
        job.dec0     = 1'b0;
        job.bm0      = 1'b0;
        job.bm1      = 1'b0;
        job.two      = 1'b0;
        if (c == CH_NUL) begin
            // A zero byte is ignored.
        end else if (c == i_cfg.eof_marker) begin
            emit    = 1'b1;
            n_state = S_NORMAL;
        end else if (rule.hit) begin
            n_state = rule.to;
            unique case (rule.act)
                A_SLASH_CHAR: begin
                    emit     = 1'b1;
                    job.ch0  = CH_SLASH;
                    job.dec0 = 1'b1;
                    job.two  = !blank_c;
                end
                A_CHAR: begin
                    emit         = 1'b1;
                    job.bm0      = r_bm_pending;
                    n_bm_pending = 1'b0;
                end
                A_MARK: n_bm_pending = 1'b1;
                A_SPACE: begin
                    emit    = 1'b1;
                    job.ch0 = CH_SPACE;
                    job.two = 1'b1;
                    job.bm1 = 1'b1;
                end
                default: ;
            endcase
        end else if (r_state == S_NORMAL) begin
            // Other bytes: at a line start (not a closing brace) skip import and using lines, else mark it.
            n_bm_pending = 1'b0;
            if (r_bm_pending && c != CH_RBRACE) begin
                if (kw_import || kw_using) begin
                    n_state = S_SKIP;
                end else begin
                    emit    = 1'b1;
                    job.bm0 = 1'b1;
                end
            end else begin
                emit = 1'b1;
            end
        end
    end

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept && emit;
    assign o_job   = job;

    // Parser state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_NORMAL;
            r_bm_pending <= 1'b0;
        end else if (accept) begin
            r_state      <= n_state;
            r_bm_pending <= n_bm_pending;
        end
    end

endmodule

// File: hdl/stn_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stn_queue: request queue
// Small register FIFO between the front and the back part so that each side
// can stall on its own.
// ----------------------------------------------------------------------------
module stn_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  stn_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output stn_pkg::t_job o_job
);
    import stn_pkg::*;

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push, do_pop;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Storage: written at the tail.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (do_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            if (do_push && !do_pop)      r_count <= r_count + 1'b1;
            else if (do_pop && !do_push) r_count <= r_count - 1'b1;
        end
    end

endmodule

// File: hdl/stn_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stn_back: output back part
// Takes requests from the queue and sends their one or two bytes through an
// output register, one byte per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module stn_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_q_valid,
    input  stn_pkg::t_job             i_q_job,
    output logic                      o_pop,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [7:0]                o_char,
    output logic [stn_pkg::IDX_W-1:0] o_source_index,
    output logic                      o_bookmark,
    output logic                      o_last
);
    import stn_pkg::*;

    logic             r_valid;
    logic             r_phase;
    logic [7:0]       r_char;
    logic [IDX_W-1:0] r_idx;
    logic             r_bm;
    logic             r_last;
    logic             load;
    logic [7:0]       n_char;
    logic [IDX_W-1:0] n_idx;
    logic             n_bm, n_last;

    assign load  = i_q_valid && (!r_valid || i_ready);
    assign o_pop = load && (r_phase || !i_q_job.two);

    // Pick the byte of the head request that goes out next.
    always_comb begin
        if (r_phase) begin
            n_char = i_q_job.ch1;
            n_idx  = i_q_job.idx;
            n_bm   = i_q_job.bm1;
            n_last = 1'b1;
        end else begin
            n_char = i_q_job.ch0;
            n_idx  = i_q_job.dec0 ? (i_q_job.idx - IDX_W'(1)) : i_q_job.idx;
            n_bm   = i_q_job.bm0;
            n_last = !i_q_job.two;
        end
    end

    // Output register and beat phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_phase <= !r_phase && i_q_job.two;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_char <= n_char;
            r_idx  <= n_idx;
            r_bm   <= n_bm;
            r_last <= n_last;
        end
    end

    assign o_valid        = r_valid;
    assign o_char         = r_char;
    assign o_source_index = r_idx;
    assign o_bookmark     = r_bm;
    assign o_last         = r_last;

endmodule

// File: hdl/source_text_normalizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_text_normalizer: source text normalizer for duplicate detection
// Path: an accepted byte's request is written into the request queue, then
// moved from the queue head into the output register, which sends it out.
// Rate: one input byte per cycle while the queue is not full; two results of
// one byte go out in turn, one byte a cycle while the output is ready.
// Reset: synchronous; parser state normal, no bookmark pending, request queue
// empty, configuration registers at their reset values.
// ----------------------------------------------------------------------------
module source_text_normalizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input stream.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // current_char[7:0], ahead_1[15:8], ahead_2[23:16], ahead_3[31:24],
    // ahead_4[39:32], ahead_5[47:40], source_index[79:48]
    input  logic [79:0] i_s_axis_tdata,
    // language[2:0]
    input  logic [2:0]  i_s_axis_tuser,
    // Output stream.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // out_char[7:0], out_source_index[39:8]
    output logic [39:0] o_m_axis_tdata,
    // starts_bookmark[0]
    output logic        o_m_axis_tuser,
    output logic        o_m_axis_tlast
);
    import stn_pkg::*;

    logic       r_word_mode;
    logic [7:0] r_eof_marker;
    logic [7:0] r_extra_blank;
    t_cfg       cfg;
    logic       cfg_wr;
    t_job       push_job, head_job;
    logic       push, pop, q_full, q_valid;
    logic [7:0] out_char;
    logic [IDX_W-1:0] out_idx;

    // Configuration registers.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_mode   <= 1'b0;
            r_eof_marker  <= EOF_MARKER_RST;
            r_extra_blank <= EXTRA_BLANK_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_WORD_MODE:   r_word_mode   <= pwdata[0];
                REG_EOF_MARKER:  r_eof_marker  <= pwdata[7:0];
                REG_EXTRA_BLANK: r_extra_blank <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Register read back.
    always_comb begin
        unique case (paddr[3:2])
            REG_WORD_MODE:   prdata = {31'd0, r_word_mode};
            REG_EOF_MARKER:  prdata = {24'd0, r_eof_marker};
            REG_EXTRA_BLANK: prdata = {24'd0, r_extra_blank};
            default:         prdata = '0;
        endcase
    end

    assign cfg.word_mode   = r_word_mode;
    assign cfg.eof_marker  = r_eof_marker;
    assign cfg.extra_blank = r_extra_blank;

    stn_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_valid        (i_s_axis_tvalid),
        .o_ready        (o_s_axis_tready),
        .i_current_char (i_s_axis_tdata[7:0]),
        .i_ahead_1      (i_s_axis_tdata[15:8]),
        .i_ahead_2      (i_s_axis_tdata[23:16]),
        .i_ahead_3      (i_s_axis_tdata[31:24]),
        .i_ahead_4      (i_s_axis_tdata[39:32]),
        .i_ahead_5      (i_s_axis_tdata[47:40]),
        .i_language     (i_s_axis_tuser),
        .i_source_index (i_s_axis_tdata[79:48]),
        .i_q_full       (q_full),
        .o_push         (push),
        .o_job          (push_job)
    );

    stn_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (head_job)
    );

    stn_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_job        (head_job),
        .o_pop          (pop),
        .o_valid        (o_m_axis_tvalid),
        .i_ready        (i_m_axis_tready),
        .o_char         (out_char),
        .o_source_index (out_idx),
        .o_bookmark     (o_m_axis_tuser),
        .o_last         (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {out_idx, out_char};

endmodule
